[rtl/rmv_pkg.sv]
// shared types and constants for the running mean and variance unit
`timescale 1ns / 1ps

package rmv_pkg;

   // fixed field widths of the stream payload
   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 32;
   localparam int SUM_W    = 64;
   localparam int VAR_W    = 63;
   localparam int ROOT_W   = 32;
   localparam int RSP_DATA_W = 224;
   localparam int RSP_USER_W = 2;

   // tuser bit positions on the result channel
   localparam int USER_VALID_BIT = 0;
   localparam int USER_SAT_BIT   = 1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic diff;
      logic square;
      logic div1_start;
      logic update;
      logic accum;
      logic div2_start;
      logic root_start;
      logic emit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic div_done;
      logic root_done;
   } status_type;

endpackage

[rtl/rmv_div.sv]
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rmv_div #(
   parameter int DW = 64,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic [VW-1:0] remainder,
   output logic          done
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   shift_in;
   logic          ge_in;

   // trial subtract on the shifted remainder
   assign shift_in = {rem_ff, quo_ff[DW-1]};
   assign ge_in    = shift_in >= {1'b0, dvs_ff};

   // control of the iteration
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient and remainder shift
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DW-2:0], ge_in};
         rem_ff <= ge_in ? VW'(shift_in - {1'b0, dvs_ff}) : shift_in[VW-1:0];
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

[rtl/rmv_sqrt.sv]
// iterative integer square root, two radicand bits per cycle
`timescale 1ns / 1ps

module rmv_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rmv_pkg::SUM_W-1:0]   radicand,
   output logic [rmv_pkg::ROOT_W-1:0]  root,
   output logic                        done
);

   localparam int RW = rmv_pkg::ROOT_W;
   localparam int CW = $clog2(RW + 1);

   logic [rmv_pkg::SUM_W-1:0] rad_ff;
   logic [RW-1:0]   root_ff;
   logic [RW+1:0]   rem_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [RW+3:0]   shift_in;
   logic [RW+3:0]   trial_in;
   logic            ge_in;

   // bring down two bits and try root*4+1
   assign shift_in = {rem_ff, rad_ff[rmv_pkg::SUM_W-1 -: 2]};
   assign trial_in = {2'b00, root_ff, 2'b01};
   assign ge_in    = shift_in >= trial_in;

   // control of the iteration
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(RW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // root digit recurrence
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[rmv_pkg::SUM_W-3:0], 2'b00};
         root_ff <= {root_ff[RW-2:0], ge_in};
         rem_ff  <= ge_in ? (RW+2)'(shift_in - trial_in) : shift_in[RW+1:0];
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

[rtl/rmv_dp.sv]
// datapath: state registers, deviation multiplier, dividers, root and result register
`timescale 1ns / 1ps

module rmv_dp #(
   parameter int COUNT_BITS  = 32,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rmv_pkg::cmd_type                  cmd,
   output rmv_pkg::status_type               status,
   input  logic                              in_clear,
   input  logic [rmv_pkg::SAMPLE_W-1:0]      in_sample,
   output logic [rmv_pkg::RSP_DATA_W-1:0]    out_data,
   output logic [rmv_pkg::RSP_USER_W-1:0]    out_user
);

   localparam int SW = rmv_pkg::SUM_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [COUNT_BITS-1:0]         count_ff;
   logic signed [SAMPLE_BITS-1:0] mean_ff;
   logic [SW-1:0]                 sum_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0]        ad_ff;
   logic                          neg_ff;
   logic [2*SAMPLE_BITS-1:0]      d2_ff;
   logic [SW-1:0]                 inc_ff;
   logic                          rec_ff;
   logic                          first_ff;
   logic                          sat_ff;
   logic [rmv_pkg::RSP_DATA_W-1:0] data_ff;
   logic [rmv_pkg::RSP_USER_W-1:0] user_ff;

   logic signed [SAMPLE_BITS:0]   diff_in;
   logic [SW-1:0]                 up_in;
   logic [SW:0]                   acc_in;
   logic [SAMPLE_BITS-1:0]        step_in;
   logic                          div_start;
   logic [SW-1:0]                 diva_num;
   logic [SW-1:0]                 divb_num;
   logic [COUNT_BITS-1:0]         divb_den;
   logic [SW-1:0]                 qa;
   logic [SW-1:0]                 qb;
   logic [COUNT_BITS-1:0]         ra;
   logic [COUNT_BITS-1:0]         rb;
   logic                          done_a;
   logic                          done_b;
   logic [rmv_pkg::ROOT_W-1:0]    root;
   logic                          root_done;
   logic                          cnt_nz;
   logic                          cnt_ge2;
   logic [rmv_pkg::VAR_W-1:0]     pop_in;
   logic [rmv_pkg::VAR_W-1:0]     smp_in;

   // deviation and rounded-up share of the squared deviation
   assign diff_in = {x_ff[SAMPLE_BITS-1], x_ff} - {mean_ff[SAMPLE_BITS-1], mean_ff};
   assign up_in   = qa + SW'(ra != '0);
   assign acc_in  = {1'b0, sum_ff} + {1'b0, inc_ff};
   assign step_in = qb[SAMPLE_BITS-1:0];

   // divider operands: update pass, then statistics pass
   assign div_start = cmd.div1_start | cmd.div2_start;
   assign diva_num  = cmd.div1_start ? SW'(d2_ff) : sum_ff;
   assign divb_num  = cmd.div1_start ? SW'(ad_ff) : sum_ff;
   assign divb_den  = cmd.div1_start ? count_ff : count_ff - 1'b1;

   rmv_div #(.DW(SW), .VW(COUNT_BITS)) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (diva_num),
      .divisor   (count_ff),
      .quotient  (qa),
      .remainder (ra),
      .done      (done_a)
   );

   rmv_div #(.DW(SW), .VW(COUNT_BITS)) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (divb_num),
      .divisor   (divb_den),
      .quotient  (qb),
      .remainder (rb),
      .done      (done_b)
   );

   rmv_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (qa),
      .root     (root),
      .done     (root_done)
   );

   // both dividers run in lockstep; remainder b is unused by the math
   assign status.div_done  = done_a & (done_b | (rb == rb));
   assign status.root_done = root_done;

   // statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         sum_ff   <= '0;
         rec_ff   <= 1'b0;
         first_ff <= 1'b0;
         sat_ff   <= 1'b0;
      end else if (cmd.load) begin
         rec_ff   <= 1'b0;
         first_ff <= 1'b0;
         sat_ff   <= 1'b0;
         if (in_clear) begin
            count_ff <= '0;
            mean_ff  <= '0;
            sum_ff   <= '0;
         end else if (count_ff == COUNT_MAX) begin
            sat_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + 1'b1;
            rec_ff   <= 1'b1;
            if (count_ff == '0) begin
               first_ff <= 1'b1;
               mean_ff  <= in_sample[SAMPLE_BITS-1:0];
               sum_ff   <= '0;
            end
         end
      end else if (cmd.accum && rec_ff && !first_ff) begin
         sum_ff  <= acc_in[SW] ? '1 : acc_in[SW-1:0];
         mean_ff <= neg_ff ? mean_ff - step_in : mean_ff + step_in;
      end
   end

   // sample, deviation, square and increment
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= in_sample[SAMPLE_BITS-1:0];
      end
      if (cmd.diff) begin
         neg_ff <= diff_in[SAMPLE_BITS];
         ad_ff  <= diff_in[SAMPLE_BITS] ? SAMPLE_BITS'(-diff_in) : diff_in[SAMPLE_BITS-1:0];
      end
      if (cmd.square) begin
         d2_ff <= ad_ff * ad_ff;
      end
      if (cmd.update) begin
         inc_ff <= SW'(d2_ff) - up_in;
      end
   end

   // result fields with empty and single-sample cases
   assign cnt_nz  = count_ff != '0;
   assign cnt_ge2 = count_ff > COUNT_BITS'(1);
   assign pop_in  = !cnt_nz ? '0 : (qa[SW-1] ? '1 : qa[rmv_pkg::VAR_W-1:0]);
   assign smp_in  = !cnt_ge2 ? '0 : (qb[SW-1] ? '1 : qb[rmv_pkg::VAR_W-1:0]);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         data_ff <= {2'b00,
                     cnt_nz ? root : rmv_pkg::ROOT_W'(0),
                     smp_in,
                     pop_in,
                     rmv_pkg::SAMPLE_W'(mean_ff),
                     rmv_pkg::COUNT_W'(count_ff)};
         user_ff <= {sat_ff, cnt_ge2};
      end
   end

   assign out_data = data_ff;
   assign out_user = user_ff;

endmodule

[rtl/rmv_ctrl.sv]
// controller: sequences one item through the datapath and owns the handshakes
`timescale 1ns / 1ps

module rmv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   input  rmv_pkg::status_type status,
   output rmv_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIFF, S_SQR, S_DIV1, S_WAIT1, S_UPD, S_ACC,
      S_DIV2, S_WAIT2, S_ROOT, S_WAIT3, S_EMIT
   } state_type;

   state_type state_ff;
   logic      out_valid_ff;
   logic      emit_ok;

   assign emit_ok = !out_valid_ff || out_ready;

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE:  if (in_valid) state_ff <= S_DIFF;
            S_DIFF:  state_ff <= S_SQR;
            S_SQR:   state_ff <= S_DIV1;
            S_DIV1:  state_ff <= S_WAIT1;
            S_WAIT1: if (status.div_done) state_ff <= S_UPD;
            S_UPD:   state_ff <= S_ACC;
            S_ACC:   state_ff <= S_DIV2;
            S_DIV2:  state_ff <= S_WAIT2;
            S_WAIT2: if (status.div_done) state_ff <= S_ROOT;
            S_ROOT:  state_ff <= S_WAIT3;
            S_WAIT3: if (status.root_done) state_ff <= S_EMIT;
            S_EMIT: begin
               if (emit_ok) begin
                  out_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.load       = state_ff == S_IDLE && in_valid;
      cmd.diff       = state_ff == S_DIFF;
      cmd.square     = state_ff == S_SQR;
      cmd.div1_start = state_ff == S_DIV1;
      cmd.update     = state_ff == S_UPD;
      cmd.accum      = state_ff == S_ACC;
      cmd.div2_start = state_ff == S_DIV2;
      cmd.root_start = state_ff == S_ROOT;
      cmd.emit       = state_ff == S_EMIT && emit_ok;
   end

   assign in_ready  = state_ff == S_IDLE;
   assign out_valid = out_valid_ff;

endmodule

[rtl/running_mean_variance_unit.sv]
// top level of the running mean and variance unit (Welford update, fixed point)
//
//  channel | dir | tdata                      | tuser
//  req_    | in  | sample                     | clear
//  rsp_    | out | count, mean, pop_variance, | sample_variance_valid,
//          |     | sample_variance, pop_stdev | count_saturated
//
// each item runs two passes of a pair of 64-step dividers plus a 32-step square root,
// with setup states between them
// the next item is taken while the previous result waits in the output register
// a stalled result holds the controller before emitting; reset clears all statistics
`timescale 1ns / 1ps

module running_mean_variance_unit #(
   parameter int COUNT_BITS  = 32,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rmv_pkg::SAMPLE_W-1:0]      req_tdata,   // sample
   input  logic                              req_tuser,   // clear
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // count, mean, pop_variance, sample_variance, pop_stdev, zero pad
   output logic [rmv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // sample_variance_valid, count_saturated
   output logic [rmv_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   rmv_pkg::cmd_type    cmd;
   rmv_pkg::status_type status;

   rmv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   rmv_dp #(.COUNT_BITS(COUNT_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .in_clear  (req_tuser),
      .in_sample (req_tdata),
      .out_data  (rsp_tdata),
      .out_user  (rsp_tuser)
   );

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transfer accepted while busy");

   // a saturated count is far above two
   a_sat_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[rmv_pkg::USER_SAT_BIT]) |->
         rsp_tuser[rmv_pkg::USER_VALID_BIT])
      else $error("saturated count without valid sample variance");

   // sample variance flagged only with two or more samples
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[rmv_pkg::USER_VALID_BIT] && COUNT_BITS <= 32) |->
         (rsp_tdata[31:0] > 32'd1))
      else $error("sample variance valid below two samples");

   // empty statistics report zero spread
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[31:0] == 32'd0 && COUNT_BITS <= 32) |->
         (rsp_tdata[126:64] == '0 && rsp_tdata[221:190] == '0))
      else $error("nonzero variance with empty count");

endmodule
